/* src/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `ASSERT_CLKD(label, clk, rst_n, !(cond), msg)

`endif

/* src/msp_pkg.sv */
`default_nettype none
package msp_pkg;

  localparam logic [7:0] CH_START = 8'h24;  // '$'
  localparam logic [7:0] CH_M     = 8'h4D;  // 'M'
  localparam logic [7:0] CH_REQ   = 8'h3C;  // '<'
  localparam logic [7:0] CH_RESP  = 8'h3E;  // '>'
  localparam logic [7:0] CH_ERR   = 8'h21;  // '!'

  localparam logic       OP_BYTE     = 1'b0;
  localparam logic       OP_LINE_ERR = 1'b1;

  localparam logic [1:0] KIND_REQ  = 2'd0;
  localparam logic [1:0] KIND_RESP = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam int unsigned QDEPTH = 2;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
    logic       buffer_full;
  } in_item_t;

  typedef struct packed {
    logic [1:0] frame_kind;
    logic [7:0] command;
    logic [7:0] length;
    logic [7:0] payload_index;
    logic [7:0] data_byte;
    logic       is_payload;
    logic       is_end;
    logic       checksum_ok;
  } out_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage
`default_nettype wire

/* src/msp_parser.sv */
`default_nettype none
module msp_parser (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  input  msp_pkg::in_item_t     in_item,
  output logic                  in_stall,
  input  msp_pkg::fifo_stat_t   q_stat,
  output logic                  push,
  output msp_pkg::out_item_t    push_item
);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SYNC_M,
    PH_DIR,
    PH_LEN,
    PH_CMD,
    PH_BODY
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] remain_r, remain_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic       accept;
  logic [7:0] b;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign b        = in_item.rx_byte;

  always_comb begin
    phase_nxt  = phase_r;
    remain_nxt = remain_r;
    kind_nxt   = kind_r;
    len_nxt    = len_r;
    cmd_nxt    = cmd_r;
    xor_nxt    = xor_r;
    push       = 1'b0;
    push_item  = '0;
    push_item.frame_kind = kind_r;
    push_item.command    = cmd_r;
    push_item.length     = len_r;
    push_item.data_byte  = b;
    if (accept) begin
      if (in_item.op == msp_pkg::OP_LINE_ERR) begin
        phase_nxt  = PH_HUNT;
        remain_nxt = '0;
        kind_nxt   = '0;
        len_nxt    = '0;
        cmd_nxt    = '0;
        xor_nxt    = '0;
      end else begin
        case (phase_r)
          PH_SYNC_M: begin
            phase_nxt = (b == msp_pkg::CH_M) ? PH_DIR : PH_HUNT;
          end
          PH_DIR: begin
            phase_nxt = PH_LEN;
            if (b == msp_pkg::CH_REQ) begin
              kind_nxt = msp_pkg::KIND_REQ;
            end else if (b == msp_pkg::CH_RESP) begin
              kind_nxt = msp_pkg::KIND_RESP;
            end else if (b == msp_pkg::CH_ERR) begin
              kind_nxt = msp_pkg::KIND_ERR;
            end else begin
              phase_nxt = PH_HUNT;
            end
          end
          PH_LEN: begin
            len_nxt    = b;
            remain_nxt = b;
            xor_nxt    = b;
            phase_nxt  = PH_CMD;
          end
          PH_CMD: begin
            cmd_nxt   = b;
            xor_nxt   = xor_r ^ b;
            phase_nxt = PH_BODY;
          end
          PH_BODY: begin
            push = 1'b1;
            if (remain_r == '0) begin
              // checksum byte closes the frame
              push_item.is_end      = 1'b1;
              push_item.checksum_ok = (xor_r == b);
              phase_nxt             = PH_HUNT;
            end else begin
              push_item.is_payload    = 1'b1;
              push_item.payload_index = len_r - remain_r;
              xor_nxt                 = xor_r ^ b;
              remain_nxt              = remain_r - 8'd1;
            end
          end
          default: begin
            phase_nxt = (!in_item.buffer_full && b == msp_pkg::CH_START) ? PH_SYNC_M
                                                                         : PH_HUNT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      remain_r <= '0;
      kind_r   <= '0;
      len_r    <= '0;
      cmd_r    <= '0;
      xor_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      remain_r <= remain_nxt;
      kind_r   <= kind_nxt;
      len_r    <= len_nxt;
      cmd_r    <= cmd_nxt;
      xor_r    <= xor_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/msp_fifo.sv */
`default_nettype none
module msp_fifo (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  msp_pkg::out_item_t   push_item,
  input  wire                  pop,
  output msp_pkg::out_item_t   head_item,
  output msp_pkg::fifo_stat_t  stat
);

  localparam int unsigned AW = $clog2(msp_pkg::QDEPTH);

  msp_pkg::out_item_t mem [msp_pkg::QDEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;
  logic          do_push, do_pop;

  assign stat.full  = (count_r == (AW+1)'(msp_pkg::QDEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_item  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/msp_out_stage.sv */
`default_nettype none
module msp_out_stage (
  input  wire                  clk,
  input  wire                  rst_n,
  input  msp_pkg::fifo_stat_t  q_stat,
  input  msp_pkg::out_item_t   head_item,
  output logic                 pop,
  output logic                 out_valid,
  output msp_pkg::out_item_t   out_item,
  input  wire                  out_stall
);

  logic               valid_r;
  msp_pkg::out_item_t item_r;
  logic               load;

  // register is free when empty or when its item leaves this edge
  assign load      = !valid_r || !out_stall;
  assign pop       = load && !q_stat.empty;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= !q_stat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= head_item;
    end
  end

endmodule
`default_nettype wire

/* src/msp_v1_frame_receiver.sv */
// msp v1 frame receiver
// in channel: one received uart byte per item (op, rx_byte, buffer_full),
//   taken when in_valid is high and in_stall is low. op high marks a line
//   error and returns the parser to hunting for '$'.
// out channel: one item per payload byte (is_payload) and one per checksum
//   byte (is_end, checksum_ok), taken when out_valid is high and out_stall
//   is low. header bytes give no item.
// throughput: one byte per cycle while in_stall is low; the parser
//   updates its state in the cycle of acceptance and writes any result
//   into a two-entry queue at the accepting edge, and the output register
//   loads it from the queue and drives out_valid.
// stall: while the receiver stalls, results collect in the queue and the
//   output register; in_stall rises only once the queue holds two items.
// reset (rst_n low, synchronous): queue and output emptied, parser hunts
//   for a start byte with header and checksum state cleared.
`default_nettype none
module msp_v1_frame_receiver (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  msp_pkg::in_item_t   in_item,
  output logic                in_stall,
  output logic                out_valid,
  output msp_pkg::out_item_t  out_item,
  input  wire                 out_stall
);

  msp_pkg::fifo_stat_t q_stat;
  msp_pkg::out_item_t  push_item;
  msp_pkg::out_item_t  head_item;
  logic                push;
  logic                pop;

  msp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  msp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .stat      (q_stat)
  );

  msp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head_item (head_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall)
  );

endmodule
`default_nettype wire

/* src/msp_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module msp_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input msp_pkg::in_item_t   in_item,
  input wire                 in_stall,
  input wire                 out_valid,
  input msp_pkg::out_item_t  out_item,
  input wire                 out_stall
);

  `ASSERT_CLKD(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_item), "stalled result changed")
  `ASSERT_CLKD(a_one_flag, clk, rst_n, out_valid |-> $onehot({out_item.is_payload, out_item.is_end}), "result must be payload or end")
  `ASSERT_NEVER(a_pay_ok, clk, rst_n, out_valid && out_item.is_payload && out_item.checksum_ok, "checksum flag on payload")
  `ASSERT_NEVER(a_end_idx, clk, rst_n, out_valid && out_item.is_end && out_item.payload_index != 8'd0, "end result with index")
  `ASSERT_CLKD(a_in_hold, clk, rst_n, in_valid && in_stall |=> in_valid && $stable(in_item), "stalled input item changed")

endmodule

bind msp_v1_frame_receiver msp_checker u_msp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_item   (in_item),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_item  (out_item),
  .out_stall (out_stall)
);
`default_nettype wire
